// File: src/swm_pkg.sv
// shared constants and control types for the sliding window maximum block
`default_nettype none
package swm_pkg;
	localparam int MAX_WINDOW   = 64;
	localparam int SAMPLE_WIDTH = 32;
	localparam int IDX_W        = $clog2(MAX_WINDOW);
	localparam int WIN_W        = 7;
	localparam int POS_W        = 7;
	localparam int ENTRY_W      = POS_W + SAMPLE_WIDTH;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3);
	localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(1);
	localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);

	typedef struct packed {
		logic accept;
		logic in_head;
		logic in_tail;
		logic head_pop;
		logic tail_pop;
		logic finish;
	} swm_cmd_t;

	typedef struct packed {
		logic head_expired;
		logic tail_not_greater;
		logic has_result;
		logic out_busy;
	} swm_status_t;
endpackage
`default_nettype wire

// File: src/swm_ram.sv
// generic single write port ram with one registered read port
`default_nettype none
module swm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: src/swm_ctrl.sv
// controller state machine for the deque engine
`default_nettype none
module swm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire swm_pkg::swm_status_t status,
	output swm_pkg::swm_cmd_t         cmd
);
	import swm_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HEAD = 2'd1;
	localparam logic [1:0] S_TAIL = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.in_head = 1'b1;
				if (status.head_expired) begin
					cmd.head_pop = 1'b1;
				end else begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				cmd.in_tail = 1'b1;
				if (status.tail_not_greater) begin
					cmd.tail_pop = 1'b1;
				end else if (!(status.has_result && status.out_busy)) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// File: src/swm_dp.sv
// datapath: deque pointers, counters, candidate store and result register
`default_nettype none
module swm_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [swm_pkg::WIN_W-1:0]           cfg_wr_data,
	input  wire logic signed [swm_pkg::SAMPLE_WIDTH-1:0] sample,
	input  wire logic                                end_of_sequence,
	input  wire swm_pkg::swm_cmd_t                   cmd,
	output swm_pkg::swm_status_t                     status,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [swm_pkg::SAMPLE_WIDTH-1:0]  window_max,
	output logic                                     sequence_done,
	output logic                                     short_window
);
	import swm_pkg::*;

	logic [WIN_W-1:0]               win_cfg_q;
	logic [WIN_W-1:0]               win_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic                           eos_q;
	logic [IDX_W-1:0]               head_q;
	logic [IDX_W-1:0]               tail_q;
	logic [WIN_W-1:0]               occ_q;
	logic [POS_W-1:0]               pos_q;
	logic [WIN_W-1:0]               seen_q;
	logic signed [SAMPLE_WIDTH-1:0] head_val_q;

	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_max_q;
	logic                           out_done_q;
	logic                           out_short_q;

	logic [IDX_W-1:0]               raddr;
	logic [ENTRY_W-1:0]             rdata;
	logic [POS_W-1:0]               rd_pos;
	logic signed [SAMPLE_WIDTH-1:0] rd_val;
	logic [POS_W-1:0]               age;
	logic [WIN_W-1:0]               seen_inc;
	logic [WIN_W-1:0]               seen_next;
	logic [WIN_W-1:0]               win_clamped;
	logic signed [SAMPLE_WIDTH-1:0] max_now;

	assign rd_pos = rdata[ENTRY_W-1 -: POS_W];
	assign rd_val = $signed(rdata[SAMPLE_WIDTH-1:0]);
	assign age    = pos_q - rd_pos;

	// clamp the window to 1..MAX_WINDOW
	always_comb begin
		if (win_cfg_q < WIN_MIN) begin
			win_clamped = WIN_MIN;
		end else if (win_cfg_q > WIN_MAX) begin
			win_clamped = WIN_MAX;
		end else begin
			win_clamped = win_cfg_q;
		end
	end

	assign seen_inc  = seen_q + WIN_W'(1);
	assign seen_next = (seen_inc > win_q) ? win_q : seen_inc;
	assign max_now   = (occ_q == '0) ? sample_q : head_val_q;

	// read address follows the next entry the engine will look at
	always_comb begin
		if (cmd.in_head) begin
			raddr = cmd.head_pop ? (head_q + IDX_W'(1)) : (tail_q - IDX_W'(1));
		end else if (cmd.in_tail) begin
			raddr = cmd.tail_pop ? (tail_q - IDX_W'(2)) : (tail_q - IDX_W'(1));
		end else begin
			raddr = head_q;
		end
	end

	always_comb begin
		status.head_expired     = (occ_q != '0) && (age >= win_q);
		status.tail_not_greater = (occ_q != '0) && (rd_val <= sample_q);
		status.has_result       = (seen_next >= win_q) || eos_q;
		status.out_busy         = out_valid_q && !out_ready;
	end

	swm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_WINDOW)
	) u_cand_ram (
		.clk  (clk),
		.we   (cmd.finish),
		.waddr(tail_q),
		.wdata({pos_q, sample_q}),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg_q   <= WIN_RESET;
			win_q       <= WIN_MIN;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			pos_q       <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				win_cfg_q <= cfg_wr_data;
			end
			if (cmd.finish && status.has_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.accept) begin
				win_q <= win_clamped;
			end
			if (cmd.head_pop) begin
				head_q <= head_q + IDX_W'(1);
				occ_q  <= occ_q - WIN_W'(1);
			end
			if (cmd.tail_pop) begin
				tail_q <= tail_q - IDX_W'(1);
				occ_q  <= occ_q - WIN_W'(1);
			end
			if (cmd.finish) begin
				if (eos_q) begin
					head_q <= '0;
					tail_q <= '0;
					occ_q  <= '0;
					pos_q  <= '0;
					seen_q <= '0;
				end else begin
					tail_q <= tail_q + IDX_W'(1);
					occ_q  <= occ_q + WIN_W'(1);
					pos_q  <= pos_q + POS_W'(1);
					seen_q <= seen_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
			eos_q    <= end_of_sequence;
		end
		if (cmd.in_head && !cmd.head_pop) begin
			head_val_q <= rd_val;
		end
		if (cmd.finish && status.has_result) begin
			out_max_q   <= max_now;
			out_done_q  <= eos_q;
			out_short_q <= (seen_next < win_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign window_max    = out_max_q;
	assign sequence_done = out_done_q;
	assign short_window  = out_short_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= WIN_MAX)
		else $error("deque occupancy beyond the store depth");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q == head_q + occ_q[IDX_W-1:0])
		else $error("tail does not match head plus occupancy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && status.has_result) |-> !status.out_busy)
		else $error("result register overwritten while waiting");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.head_pop || cmd.tail_pop) |-> (occ_q != '0))
		else $error("pop from an empty deque");
endmodule
`default_nettype wire

// File: src/sliding_window_maximum_top.sv
// top level of the sliding window maximum block
// flow: a word is taken in the idle state, then the head state ages out expired
//   candidates and the tail state drops smaller tail candidates and pushes the word;
//   the push waits while an earlier result is unaccepted and a new one is due; any
//   result word is valid the cycle after the push; a new word is taken only in the
//   idle state, and both deque ends share the single read port of the candidate ram
// reset: arst_n clears the deque, counters and output valid at once; window_size
//   returns to 3; the candidate ram is not cleared, the occupancy count guards reads
`default_nettype none
module sliding_window_maximum_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration: one register, written whenever the enable is high
	input  wire logic                               cfg_wr_en,
	input  wire logic [swm_pkg::WIN_W-1:0]          cfg_wr_data,
	// input words
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [swm_pkg::SAMPLE_WIDTH-1:0] sample,
	input  wire logic                               end_of_sequence,
	// result words
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [swm_pkg::SAMPLE_WIDTH-1:0] window_max,
	output logic                                    sequence_done,
	output logic                                    short_window
);
	import swm_pkg::*;

	swm_cmd_t    cmd;
	swm_status_t status;

	// sequencer: idle, age out head, trim tail and push
	swm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	// deque storage, pointers, counters and the output register, which lets
	// a new word in while a finished result still waits
	swm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.sample         (sample),
		.end_of_sequence(end_of_sequence),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.window_max     (window_max),
		.sequence_done  (sequence_done),
		.short_window   (short_window)
	);
endmodule
`default_nettype wire
